@@ rtl/oht_pkg.sv @@
// shared types, codes and helpers for the object handle table
`default_nettype none

package oht_pkg;

    // default sizing
    localparam int OHT_ENTRIES      = 16;
    localparam int OHT_PAYLOAD_BITS = 32;

    // request codes
    localparam logic [1:0] REQ_PUT    = 2'd0;
    localparam logic [1:0] REQ_FIND   = 2'd1;
    localparam logic [1:0] REQ_GET    = 2'd2;
    localparam logic [1:0] REQ_REMOVE = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOMEM    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    // first handle handed out after reset
    localparam logic [31:0] HANDLE_INIT = 32'd1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] handle_in;
        logic [31:0] parent_in;
        logic [63:0] name_in;
        logic [31:0] payload_in;
    } oht_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] handle_out;
        logic [31:0] parent_out;
        logic [63:0] name_out;
        logic [31:0] payload_out;
    } oht_rsp_t;

    // lookup key of one entry
    typedef struct packed {
        logic [31:0] handle;
        logic [31:0] parent;
        logic [63:0] name;
    } oht_key_t;

    // one table entry without its payload
    typedef struct packed {
        logic     valid;
        oht_key_t key;
    } oht_entry_t;

    // clear every byte from the first nul byte on
    function automatic logic [63:0] name_norm(input logic [63:0] n);
        logic [63:0] r;
        logic        live;
        begin
            r    = '0;
            live = 1'b1;
            for (int k = 0; k < 8; k++) begin
                if (n[8*k +: 8] == 8'h00) begin
                    live = 1'b0;
                end
                if (live) begin
                    r[8*k +: 8] = n[8*k +: 8];
                end
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/oht_table.sv @@
// entry storage: one write port, one registered read port
`default_nettype none

module oht_table
    import oht_pkg::*;
#(
    parameter int ENTRIES      = OHT_ENTRIES,
    parameter int PAYLOAD_BITS = OHT_PAYLOAD_BITS
) (
    input  wire logic                                       aclk,
    input  wire logic                                       wr_valid_en,
    input  wire logic                                       wr_data_en,
    input  wire logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
    input  wire oht_entry_t                                 wr_entry,
    input  wire logic [((PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32)-1:0] wr_payload,
    input  wire logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
    output oht_entry_t                                      rd_entry,
    output logic [((PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32)-1:0] rd_payload
);

    localparam int PW = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;

    logic           valid_mem   [ENTRIES];
    oht_key_t       key_mem     [ENTRIES];
    logic [PW-1:0]  payload_mem [ENTRIES];

    logic           rd_valid_reg;
    oht_key_t       rd_key_reg;
    logic [PW-1:0]  rd_payload_reg;

    always_ff @(posedge aclk) begin
        if (wr_valid_en) begin
            valid_mem[wr_addr] <= wr_entry.valid;
        end
        if (wr_data_en) begin
            key_mem[wr_addr]     <= wr_entry.key;
            payload_mem[wr_addr] <= wr_payload;
        end
        rd_valid_reg   <= valid_mem[rd_addr];
        rd_key_reg     <= key_mem[rd_addr];
        rd_payload_reg <= payload_mem[rd_addr];
    end

    assign rd_entry.valid = rd_valid_reg;
    assign rd_entry.key   = rd_key_reg;
    assign rd_payload     = rd_payload_reg;

endmodule

`default_nettype wire

@@ rtl/oht_match.sv @@
// shared compare unit: tests one stored entry against the request
`default_nettype none

module oht_match
    import oht_pkg::*;
(
    input  wire logic [1:0] req_type,
    input  wire oht_key_t   key,
    input  wire oht_entry_t entry,
    output logic            hit
);

    always_comb begin
        case (req_type)
            REQ_PUT: begin
                hit = !entry.valid;
            end
            REQ_FIND: begin
                hit = entry.valid && (entry.key.parent == key.parent)
                      && (entry.key.name == key.name);
            end
            REQ_GET, REQ_REMOVE: begin
                hit = entry.valid && (entry.key.handle == key.handle);
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/object_handle_table_core.sv @@
// object handle table: top level with request sequencer and result register
//
// usage
//   s_valid/s_ready/s_req carries one request word: put, find by parent and
//   name, get by handle, or remove by handle. m_valid/m_ready/m_rsp returns
//   exactly one result word per request, in request order.
//   a request is served by scanning the table one entry per cycle from slot 0
//   through one shared compare unit; the first hit ends the scan. a put
//   searches for the lowest free slot and stamps it with the handle counter.
// read path
//   the table memory has a registered read, so each entry is judged from
//   the read data register; the hit, or the miss in the last slot, goes to
//   a result register and then to the output register. the next request
//   is taken once the result is handed over.
// reset
//   aresetn is synchronous, active low. after reset the sequencer sweeps the
//   table and clears every valid mark, one slot per cycle, with s_ready low;
//   the handle counter restarts at 1.
// stalls
//   a finished result waits in the output register while m_ready is low; the
//   next request is still taken and scanned, and only its own hand-over
//   waits for the output register to drain.
`default_nettype none

module object_handle_table_core
    import oht_pkg::*;
#(
    parameter int ENTRIES      = OHT_ENTRIES,
    parameter int PAYLOAD_BITS = OHT_PAYLOAD_BITS
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire oht_req_t s_req,
    output logic          m_valid,
    input  wire logic     m_ready,
    output oht_rsp_t      m_rsp
);

    localparam int              IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int              PW       = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // sequencer states
    localparam logic [1:0] S_CLEAR = 2'd0;   // valid mark sweep after reset
    localparam logic [1:0] S_IDLE  = 2'd1;   // waiting for a request word
    localparam logic [1:0] S_SCAN  = 2'd2;   // one entry per cycle
    localparam logic [1:0] S_DONE  = 2'd3;   // result waits for the output

    logic [1:0]       state_reg,      state_next;
    logic [1:0]       req_type_reg,   req_type_next;
    oht_key_t         key_reg,        key_next;
    logic [PW-1:0]    payload_reg,    payload_next;
    logic [IDX_W-1:0] scan_idx_reg,   scan_idx_next;    // read address issued
    logic [IDX_W-1:0] cmp_idx_reg,    cmp_idx_next;     // slot of the read data
    logic             rd_live_reg,    rd_live_next;     // read data belongs to scan
    logic             issue_done_reg, issue_done_next;  // last slot issued
    logic [31:0]      next_handle_reg, next_handle_next;
    oht_rsp_t         res_reg,        res_next;
    logic             m_valid_reg,    m_valid_next;
    oht_rsp_t         m_rsp_reg,      m_rsp_next;

    // table ports
    logic             wr_valid_en;
    logic             wr_data_en;
    logic [IDX_W-1:0] wr_addr;
    oht_entry_t       wr_entry;
    oht_entry_t       rd_entry;
    logic [PW-1:0]    rd_payload;
    logic             hit;

    oht_table #(
        .ENTRIES      (ENTRIES),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_table (
        .aclk        (aclk),
        .wr_valid_en (wr_valid_en),
        .wr_data_en  (wr_data_en),
        .wr_addr     (wr_addr),
        .wr_entry    (wr_entry),
        .wr_payload  (payload_reg),
        .rd_addr     (scan_idx_reg),
        .rd_entry    (rd_entry),
        .rd_payload  (rd_payload)
    );

    oht_match u_match (
        .req_type (req_type_reg),
        .key      (key_reg),
        .entry    (rd_entry),
        .hit      (hit)
    );

    // write port: clear sweep, put stamp, or remove
    always_comb begin
        wr_valid_en        = 1'b0;
        wr_data_en         = 1'b0;
        wr_addr            = cmp_idx_reg;
        wr_entry.valid     = (req_type_reg == REQ_PUT);
        wr_entry.key.handle = next_handle_reg;
        wr_entry.key.parent = key_reg.parent;
        wr_entry.key.name   = key_reg.name;
        if (state_reg == S_CLEAR) begin
            wr_addr        = scan_idx_reg;
            wr_valid_en    = 1'b1;
            wr_entry.valid = 1'b0;
        end else if (state_reg == S_SCAN && rd_live_reg && hit) begin
            if (req_type_reg == REQ_PUT) begin
                wr_valid_en = 1'b1;
                wr_data_en  = 1'b1;
            end else if (req_type_reg == REQ_REMOVE) begin
                wr_valid_en = 1'b1;
            end
        end
    end

    always_comb begin
        state_next       = state_reg;
        req_type_next    = req_type_reg;
        key_next         = key_reg;
        payload_next     = payload_reg;
        scan_idx_next    = scan_idx_reg;
        cmp_idx_next     = cmp_idx_reg;
        rd_live_next     = rd_live_reg;
        issue_done_next  = issue_done_reg;
        next_handle_next = next_handle_reg;
        res_next         = res_reg;
        m_valid_next     = m_valid_reg;
        m_rsp_next       = m_rsp_reg;

        // output word taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                if (scan_idx_reg == LAST_IDX) begin
                    scan_idx_next = '0;
                    state_next    = S_IDLE;
                end else begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    req_type_next   = s_req.req_type;
                    key_next.handle = s_req.handle_in;
                    key_next.parent = s_req.parent_in;
                    key_next.name   = name_norm(s_req.name_in);
                    payload_next    = s_req.payload_in[PW-1:0];
                    scan_idx_next   = '0;
                    rd_live_next    = 1'b0;
                    issue_done_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue the next read
                if (!issue_done_reg) begin
                    cmp_idx_next = scan_idx_reg;
                    rd_live_next = 1'b1;
                    if (scan_idx_reg == LAST_IDX) begin
                        issue_done_next = 1'b1;
                    end else begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                    end
                end else begin
                    rd_live_next = 1'b0;
                end
                // judge the entry read last cycle
                if (rd_live_reg) begin
                    if (hit) begin
                        res_next.status = ST_OK;
                        if (req_type_reg == REQ_PUT) begin
                            res_next.handle_out  = next_handle_reg;
                            res_next.parent_out  = key_reg.parent;
                            res_next.name_out    = key_reg.name;
                            res_next.payload_out = 32'(payload_reg);
                            next_handle_next     = next_handle_reg + 32'd1;
                        end else begin
                            res_next.handle_out  = rd_entry.key.handle;
                            res_next.parent_out  = rd_entry.key.parent;
                            res_next.name_out    = rd_entry.key.name;
                            res_next.payload_out = 32'(rd_payload);
                        end
                        state_next = S_DONE;
                    end else if (cmp_idx_reg == LAST_IDX) begin
                        res_next.status      = (req_type_reg == REQ_PUT) ? ST_NOMEM
                                                                         : ST_NOTFOUND;
                        res_next.handle_out  = '0;
                        res_next.parent_out  = '0;
                        res_next.name_out    = '0;
                        res_next.payload_out = '0;
                        state_next           = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_rsp_next   = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            scan_idx_reg    <= '0;
            rd_live_reg     <= 1'b0;
            issue_done_reg  <= 1'b0;
            next_handle_reg <= HANDLE_INIT;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            scan_idx_reg    <= scan_idx_next;
            rd_live_reg     <= rd_live_next;
            issue_done_reg  <= issue_done_next;
            next_handle_reg <= next_handle_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        req_type_reg <= req_type_next;
        key_reg      <= key_next;
        payload_reg  <= payload_next;
        cmp_idx_reg  <= cmp_idx_next;
        res_reg      <= res_next;
        m_rsp_reg    <= m_rsp_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

endmodule

`default_nettype wire
